### hdl/evag_pkg.sv
`default_nettype none

package evag_pkg;

  // Register field widths
  localparam int FLEN_W     = 12;
  localparam int LVL_W      = 15;
  localparam int LEN_W      = 16;
  localparam int PAD_W      = 14;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Frame fill counter and run counter
  localparam int FILL_W   = 13;
  localparam int FILL_MAX = 4096;
  localparam logic [FILL_W-1:0] FILL_FULL = 13'd4096;
  localparam int RUN_W    = 17;
  localparam logic [RUN_W-1:0] RUN_MAX = 17'h1FFFF;

  // Register reset values
  localparam logic              ENABLE_RST       = 1'b1;
  localparam logic [FLEN_W-1:0] FRAME_LENGTH_RST = 12'd480;
  localparam logic [LVL_W-1:0]  SPEECH_LEVEL_RST = 15'd1000;
  localparam logic [LVL_W-1:0]  QUIET_LEVEL_RST  = 15'd500;
  localparam logic [LEN_W-1:0]  MIN_SPEECH_RST   = 16'd4800;
  localparam logic [LEN_W-1:0]  MIN_QUIET_RST    = 16'd8000;
  localparam logic [PAD_W-1:0]  PRE_ROLL_RST     = 14'd4800;
  localparam logic [PAD_W-1:0]  POST_PAD_RST     = 14'd3200;

  // Item modes
  localparam logic MODE_PUSH  = 1'b0;
  localparam logic MODE_DRAIN = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ENABLE,
    CFG_FRAME_LENGTH,
    CFG_SPEECH_LEVEL,
    CFG_QUIET_LEVEL,
    CFG_MIN_SPEECH,
    CFG_MIN_QUIET,
    CFG_PRE_ROLL,
    CFG_POST_PAD
  } cfg_index_t;

  typedef enum logic [1:0] {
    ST_SILENCE,
    ST_ONSET,
    ST_SPEAKING,
    ST_OFFSET
  } gate_state_t;

endpackage

`default_nettype wire

### hdl/evag_ram.sv
`default_nettype none

module evag_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### hdl/energy_voice_activity_gate.sv
// Energy voice activity gate.
// Input channel (in_valid/in_ready) carries one item: mode 0 pushes sample_in into the
// ring memory, mode 1 drains one released sample. block_end on a push closes the frame.
// Output channel (res_valid/res_ready) carries one result per drain, and one per push
// while enable is 0 (the sample passed straight through). Gated pushes give no result.
// Configuration is a plain write port (cfg_we, cfg_index, cfg_data), written while idle.
// Throughput: one item per cycle while in_ready is high. A push that closes a frame holds
// in_ready low in close_s1, the threshold multiply, then in close_s2, the gate state
// update on the pointers. A result passes the result stage, where the ring read completes,
// and then the result queue before it is presented. Results leave in item order through a
// three-entry queue; when the receiver stalls, in_ready drops once queued plus in-flight
// results reach three.
// Reset clears pointers, gate state, frame energy, run count and overrun, and loads the
// register defaults. The ring memory itself is not cleared and needs no clearing pass:
// the gate never releases an entry that was not written.
`default_nettype none

module energy_voice_activity_gate
  import evag_pkg::*;
#(
  parameter int RING_DEPTH   = 16384,
  parameter int SAMPLE_WIDTH = 16
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic                           mode,
  input  wire logic signed [SAMPLE_WIDTH-1:0] sample_in,
  input  wire logic                           block_end,
  output logic                                res_valid,
  input  wire logic                           res_ready,
  output logic signed      [SAMPLE_WIDTH-1:0] sample_out,
  output logic                                out_valid,
  output logic                                speaking,
  output logic                                overrun,
  input  wire logic                           cfg_we,
  input  wire logic        [CFG_IDX_W-1:0]    cfg_index,
  input  wire logic        [CFG_DATA_W-1:0]   cfg_data
);

  localparam int PW        = $clog2(RING_DEPTH);
  localparam int EW        = 2 * SAMPLE_WIDTH + 10;
  localparam int SQW       = 2 * SAMPLE_WIDTH;
  localparam int SQL_W     = 2 * LVL_W;
  localparam int LIM_W     = SQL_W + FILL_W;
  localparam int CMP_W     = (EW > LIM_W) ? EW : LIM_W;
  localparam int DW        = (PW > PAD_W) ? PW : PAD_W;
  localparam int MW        = (FILL_W > PW + 1) ? FILL_W : PW + 1;
  localparam int LEN_WRAPS = FILL_MAX / RING_DEPTH;
  localparam int Q_DEPTH   = 3;
  localparam int Q_AW      = 2;
  localparam logic [PW:0]      DEPTH_W = (PW + 1)'(RING_DEPTH);
  localparam logic [PW-1:0]    FULL_DIST = PW'(RING_DEPTH - 1);
  localparam logic [EW-1:0]    ENERGY_MAX = {EW{1'b1}};
  localparam logic [Q_AW-1:0]  Q_LAST = Q_AW'(Q_DEPTH - 1);
  localparam logic [Q_AW:0]    Q_FULL = (Q_AW + 1)'(Q_DEPTH);

  typedef struct packed {
    logic [SAMPLE_WIDTH-1:0] sample;
    logic                    flag;
    logic                    speaking;
    logic                    overrun;
  } res_t;

  function automatic logic [PW-1:0] ring_add(input logic [PW-1:0] p, input logic [PW-1:0] n);
    logic [PW:0] s;
    s = {1'b0, p} + {1'b0, n};
    if (s >= DEPTH_W) begin
      s = s - DEPTH_W;
    end
    return s[PW-1:0];
  endfunction

  function automatic logic [PW-1:0] ring_sub(input logic [PW-1:0] p, input logic [PW-1:0] n);
    logic [PW:0] s;
    if (p >= n) begin
      s = {1'b0, p} - {1'b0, n};
    end else begin
      s = {1'b0, p} + DEPTH_W - {1'b0, n};
    end
    return s[PW-1:0];
  endfunction

  // Configuration registers
  logic              enable;
  logic [FLEN_W-1:0] frame_length;
  logic [LVL_W-1:0]  speech_level;
  logic [LVL_W-1:0]  quiet_level;
  logic [LEN_W-1:0]  min_speech_len;
  logic [LEN_W-1:0]  min_quiet_len;
  logic [PAD_W-1:0]  pre_roll_max;
  logic [PAD_W-1:0]  post_pad_max;

  // Gate state
  logic [PW-1:0]     write_ptr, write_ptr_next;
  logic [PW-1:0]     kept_start_ptr, kept_start_ptr_next;
  logic [PW-1:0]     segment_start_ptr, segment_start_ptr_next;
  logic [PW-1:0]     drain_ptr, drain_ptr_next;
  logic [PW-1:0]     release_end_ptr, release_end_ptr_next;
  gate_state_t       gate_state, gate_state_next;
  logic [RUN_W-1:0]  run_count, run_count_next;
  logic [FILL_W-1:0] frame_fill, frame_fill_next;
  logic              overrun_flag, overrun_flag_next;
  logic [EW-1:0]     frame_energy;

  // Energy and threshold datapath
  logic [SAMPLE_WIDTH-1:0] mag;
  logic [SQW-1:0]          sq;
  logic                    sq_vld;
  logic [EW:0]             energy_sum;
  logic [SQL_W-1:0]        speech_sq, quiet_sq;
  logic [LIM_W-1:0]        speech_lim, quiet_lim;
  logic [MW-1:0]           len_wrap;
  logic [PW-1:0]           len_mod;
  logic                    close_s1, close_s2, close_start;
  logic                    is_speech, is_quiet;

  // Item decode and close helpers
  logic              in_fire;
  logic [PW-1:0]     oldest;
  logic [FILL_W-1:0] limit, fill_after;
  logic [PW-1:0]     fstart, held, pad, kept_trim;
  logic              trim_hit;
  logic [RUN_W:0]    run_sum;
  logic [RUN_W-1:0]  run_plus;
  logic              rel;
  logic [PW-1:0]     rel_start, rel_end;
  logic              ram_we;
  logic [SAMPLE_WIDTH-1:0] ram_rdata;

  // Result stage and queue
  logic                    p_load, p_valid;
  logic                    p_ram, p_ram_next;
  logic [SAMPLE_WIDTH-1:0] p_sample, p_sample_next;
  logic                    p_flag, p_flag_next;
  logic                    p_speaking, p_overrun;
  res_t                    q_mem [Q_DEPTH];
  logic [Q_AW-1:0]         q_head, q_tail;
  logic [Q_AW-1:0]         q_cnt;
  logic                    q_pop;
  logic [Q_AW:0]           q_credit;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      enable         <= ENABLE_RST;
      frame_length   <= FRAME_LENGTH_RST;
      speech_level   <= SPEECH_LEVEL_RST;
      quiet_level    <= QUIET_LEVEL_RST;
      min_speech_len <= MIN_SPEECH_RST;
      min_quiet_len  <= MIN_QUIET_RST;
      pre_roll_max   <= PRE_ROLL_RST;
      post_pad_max   <= POST_PAD_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ENABLE:       enable         <= cfg_data[0];
        CFG_FRAME_LENGTH: frame_length   <= cfg_data[FLEN_W-1:0];
        CFG_SPEECH_LEVEL: speech_level   <= cfg_data[LVL_W-1:0];
        CFG_QUIET_LEVEL:  quiet_level    <= cfg_data[LVL_W-1:0];
        CFG_MIN_SPEECH:   min_speech_len <= cfg_data[LEN_W-1:0];
        CFG_MIN_QUIET:    min_quiet_len  <= cfg_data[LEN_W-1:0];
        CFG_PRE_ROLL:     pre_roll_max   <= cfg_data[PAD_W-1:0];
        CFG_POST_PAD:     post_pad_max   <= cfg_data[PAD_W-1:0];
        default: ;
      endcase
    end
  end

  // Ring memory: push writes at write_ptr, drain reads at drain_ptr.
  // A written entry is released no earlier than a frame close, which holds the input
  // through close_s1 and close_s2, so a drain never reads an entry in the cycle after its write.
  evag_ram #(
    .WIDTH(SAMPLE_WIDTH),
    .DEPTH(RING_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (write_ptr),
    .wdata (sample_in),
    .raddr (drain_ptr),
    .rdata (ram_rdata)
  );

  // Hold input while a frame close is in flight or the result queue has no room
  assign q_credit = {1'b0, q_cnt} + {{Q_AW{1'b0}}, p_valid};
  assign in_ready = !close_s1 && !close_s2 && (q_credit < Q_FULL);
  assign in_fire  = in_valid && in_ready;

  // Magnitude of the pushed sample
  assign mag = sample_in[SAMPLE_WIDTH-1] ? (~sample_in + SAMPLE_WIDTH'(1)) : sample_in;

  // Square, then accumulate next cycle with saturation
  assign energy_sum = {1'b0, frame_energy} + (EW + 1)'(sq);

  always_ff @(posedge clk) begin
    sq <= mag * mag;
    if (rst) begin
      sq_vld       <= 1'b0;
      frame_energy <= '0;
      close_s1     <= 1'b0;
      close_s2     <= 1'b0;
    end else begin
      sq_vld   <= ram_we;
      close_s1 <= close_start;
      close_s2 <= close_s1;
      if (close_s2) begin
        frame_energy <= '0;
      end else if (sq_vld) begin
        frame_energy <= energy_sum[EW] ? ENERGY_MAX : energy_sum[EW-1:0];
      end
    end
  end

  // Fold the frame fill count back into ring range
  always_comb begin
    len_wrap = MW'(frame_fill);
    for (int i = 0; i < LEN_WRAPS; i++) begin
      if (len_wrap >= MW'(RING_DEPTH)) begin
        len_wrap = len_wrap - MW'(RING_DEPTH);
      end
    end
  end

  // Level squares, then thresholds scaled by the frame fill count
  always_ff @(posedge clk) begin
    speech_sq  <= speech_level * speech_level;
    quiet_sq   <= quiet_level * quiet_level;
    speech_lim <= speech_sq * frame_fill;
    quiet_lim  <= quiet_sq * frame_fill;
    len_mod    <= PW'(len_wrap);
  end

  assign is_speech = CMP_W'(frame_energy) >= CMP_W'(speech_lim);
  assign is_quiet  = CMP_W'(frame_energy) <  CMP_W'(quiet_lim);

  // Close helpers
  assign fstart    = ring_sub(write_ptr, len_mod);
  assign trim_hit  = DW'(ring_sub(write_ptr, kept_start_ptr)) > DW'(pre_roll_max);
  assign kept_trim = ring_sub(write_ptr, PW'(pre_roll_max));
  assign held      = ring_sub(write_ptr, segment_start_ptr);
  assign pad       = (DW'(post_pad_max) < DW'(held)) ? PW'(post_pad_max) : held;
  assign run_sum   = {1'b0, run_count} + (RUN_W + 1)'(frame_fill);
  assign run_plus  = (run_sum > {1'b0, RUN_MAX}) ? RUN_MAX : run_sum[RUN_W-1:0];
  assign oldest    = (drain_ptr != release_end_ptr) ? drain_ptr : kept_start_ptr;
  assign limit     = (frame_length == '0) ? FILL_FULL : FILL_W'(frame_length);

  // Item handling and frame close decision
  always_comb begin
    write_ptr_next         = write_ptr;
    kept_start_ptr_next    = kept_start_ptr;
    segment_start_ptr_next = segment_start_ptr;
    drain_ptr_next         = drain_ptr;
    release_end_ptr_next   = release_end_ptr;
    gate_state_next        = gate_state;
    run_count_next         = run_count;
    frame_fill_next        = frame_fill;
    overrun_flag_next      = overrun_flag;
    fill_after             = frame_fill;
    ram_we                 = 1'b0;
    close_start            = 1'b0;
    p_load                 = 1'b0;
    p_ram_next             = 1'b0;
    p_flag_next            = 1'b0;
    p_sample_next          = sample_in;
    rel                    = 1'b0;
    rel_start              = kept_start_ptr;
    rel_end                = write_ptr;

    if (in_fire) begin
      if (mode == MODE_DRAIN) begin
        // Drain one released sample, or report empty
        p_load = 1'b1;
        if (drain_ptr != release_end_ptr) begin
          p_ram_next     = 1'b1;
          p_flag_next    = 1'b1;
          drain_ptr_next = ring_add(drain_ptr, PW'(1));
        end else begin
          p_sample_next = '0;
        end
      end else if (!enable) begin
        // Pass the sample straight through
        p_load      = 1'b1;
        p_flag_next = 1'b1;
      end else begin
        // Store the sample unless the ring is full, then check for frame end
        if (ring_sub(write_ptr, oldest) >= FULL_DIST) begin
          overrun_flag_next = 1'b1;
        end else begin
          ram_we         = 1'b1;
          write_ptr_next = ring_add(write_ptr, PW'(1));
          fill_after     = frame_fill + FILL_W'(1);
        end
        frame_fill_next = fill_after;
        if ((fill_after != '0) && ((fill_after >= limit) || block_end)) begin
          close_start = 1'b1;
        end
      end
    end else if (close_s2) begin
      frame_fill_next = '0;
      case (gate_state)
        ST_SILENCE: begin
          if (is_speech) begin
            gate_state_next        = ST_ONSET;
            segment_start_ptr_next = fstart;
            run_count_next         = RUN_W'(frame_fill);
          end else if (trim_hit) begin
            kept_start_ptr_next = kept_trim;
          end
        end
        ST_ONSET: begin
          if (is_speech) begin
            run_count_next = run_plus;
            if (run_plus >= RUN_W'(min_speech_len)) begin
              rel                    = 1'b1;
              kept_start_ptr_next    = write_ptr;
              segment_start_ptr_next = write_ptr;
              run_count_next         = '0;
              gate_state_next        = ST_SPEAKING;
            end
          end else begin
            if (trim_hit) begin
              kept_start_ptr_next = kept_trim;
            end
            run_count_next  = '0;
            gate_state_next = ST_SILENCE;
          end
        end
        ST_SPEAKING: begin
          if (is_quiet) begin
            segment_start_ptr_next = fstart;
            kept_start_ptr_next    = fstart;
            run_count_next         = RUN_W'(frame_fill);
            gate_state_next        = ST_OFFSET;
          end else begin
            rel                 = 1'b1;
            kept_start_ptr_next = write_ptr;
          end
        end
        default: begin
          rel_start = segment_start_ptr;
          if (is_quiet) begin
            run_count_next = run_plus;
            if (run_plus >= RUN_W'(min_quiet_len)) begin
              // Release the hangover, trimmed to the padding limit
              rel                    = 1'b1;
              rel_end                = ring_add(segment_start_ptr, pad);
              kept_start_ptr_next    = write_ptr;
              segment_start_ptr_next = write_ptr;
              run_count_next         = '0;
              gate_state_next        = ST_SILENCE;
            end
          end else begin
            rel                    = 1'b1;
            kept_start_ptr_next    = write_ptr;
            segment_start_ptr_next = write_ptr;
            run_count_next         = '0;
            gate_state_next        = ST_SPEAKING;
          end
        end
      endcase
      // Extend the released range; restart draining if it was empty
      if (rel) begin
        if (drain_ptr == release_end_ptr) begin
          drain_ptr_next = rel_start;
        end
        release_end_ptr_next = rel_end;
      end
    end
  end

  // Gate state register
  always_ff @(posedge clk) begin
    if (rst) begin
      gate_state <= ST_SILENCE;
    end else begin
      gate_state <= gate_state_next;
    end
  end

  // Pointer and counter registers
  always_ff @(posedge clk) begin
    if (rst) begin
      write_ptr         <= '0;
      kept_start_ptr    <= '0;
      segment_start_ptr <= '0;
      drain_ptr         <= '0;
      release_end_ptr   <= '0;
      run_count         <= '0;
      frame_fill        <= '0;
      overrun_flag      <= 1'b0;
    end else begin
      write_ptr         <= write_ptr_next;
      kept_start_ptr    <= kept_start_ptr_next;
      segment_start_ptr <= segment_start_ptr_next;
      drain_ptr         <= drain_ptr_next;
      release_end_ptr   <= release_end_ptr_next;
      run_count         <= run_count_next;
      frame_fill        <= frame_fill_next;
      overrun_flag      <= overrun_flag_next;
    end
  end

  // Result stage: holds the item while the ring read completes
  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else begin
      p_valid <= p_load;
    end
    if (p_load) begin
      p_ram      <= p_ram_next;
      p_sample   <= p_sample_next;
      p_flag     <= p_flag_next;
      p_speaking <= (gate_state == ST_SPEAKING) || (gate_state == ST_OFFSET);
      p_overrun  <= overrun_flag;
    end
  end

  // Result queue
  assign q_pop = res_valid && res_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_head <= '0;
      q_tail <= '0;
      q_cnt  <= '0;
    end else begin
      if (p_valid) begin
        q_tail <= (q_tail == Q_LAST) ? '0 : q_tail + Q_AW'(1);
      end
      if (q_pop) begin
        q_head <= (q_head == Q_LAST) ? '0 : q_head + Q_AW'(1);
      end
      if (p_valid && !q_pop) begin
        q_cnt <= q_cnt + Q_AW'(1);
      end else if (!p_valid && q_pop) begin
        q_cnt <= q_cnt - Q_AW'(1);
      end
    end
    if (p_valid) begin
      q_mem[q_tail] <= '{
        sample:   p_ram ? ram_rdata : p_sample,
        flag:     p_flag,
        speaking: p_speaking,
        overrun:  p_overrun
      };
    end
  end

  assign res_valid  = (q_cnt != '0);
  assign sample_out = q_mem[q_head].sample;
  assign out_valid  = q_mem[q_head].flag;
  assign speaking   = q_mem[q_head].speaking;
  assign overrun    = q_mem[q_head].overrun;

endmodule

`default_nettype wire

### hdl/evag_chk.sv
`default_nettype none

module evag_chk #(
  parameter int SAMPLE_WIDTH = 16
) (
  input wire logic                           clk,
  input wire logic                           rst,
  input wire logic                           in_ready,
  input wire logic                           res_valid,
  input wire logic                           res_ready,
  input wire logic signed [SAMPLE_WIDTH-1:0] sample_out,
  input wire logic                           out_valid
);

  // Reset empties the result queue
  a_reset_empty: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result pending right after reset");

  // Reset leaves no frame close in flight and room for an item
  a_reset_ready: assert property (@(posedge clk) rst |=> in_ready)
    else $error("input not ready right after reset");

  // An empty drain carries a zero sample
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !out_valid) |-> (sample_out == '0))
    else $error("empty drain result with nonzero sample");

  // A stalled result holds
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_ready) |=> (res_valid && $stable(sample_out) && $stable(out_valid)))
    else $error("stalled result changed");

endmodule

bind energy_voice_activity_gate evag_chk #(
  .SAMPLE_WIDTH(SAMPLE_WIDTH)
) u_evag_chk (
  .clk        (clk),
  .rst        (rst),
  .in_ready   (in_ready),
  .res_valid  (res_valid),
  .res_ready  (res_ready),
  .sample_out (sample_out),
  .out_valid  (out_valid)
);

`default_nettype wire
